// File: rtl/core/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants for the positional array list
// Operation and status codes, list sizing and the command word that the
// top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int LIST_CAPACITY = 16;
  localparam int WORD_W        = 32;
  localparam int POS_W         = 5;
  localparam int CNT_W         = $clog2(LIST_CAPACITY + 1);
  localparam int IDX_W         = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int CMP_W         = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    KIND_INSERT   = 3'd0,
    KIND_DELETE   = 3'd1,
    KIND_RETRIEVE = 3'd2,
    KIND_LOCATE   = 3'd3,
    KIND_CLEAR    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Broadcast to all cells in the execute cycle
  typedef struct packed {
    logic  ins;     // insert succeeds: open a slot at pos_m1
    logic  del;     // delete succeeds: close the slot at pos_m1
    cnt_t  pos_m1;  // zero-based position
    word_t val;     // word to insert or to compare
    cnt_t  count;   // current entry count
  } cmd_t;

endpackage

// File: rtl/core/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell: one slot of the list
// Holds one word, loads a new word or takes a neighbor's word on a shift,
// and flags a match against the broadcast search word.
// ----------------------------------------------------------------------------
module pal_cell (
  input  logic          clk_i,
  input  pal_pkg::cmd_t cmd_i,
  input  pal_pkg::cnt_t idx_i,
  input  pal_pkg::word_t left_i,
  input  pal_pkg::word_t right_i,
  output pal_pkg::word_t word_o,
  output logic          match_o
);
  import pal_pkg::*;

  word_t word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (cmd_i.ins) begin
      if (idx_i == cmd_i.pos_m1) begin
        word_d = cmd_i.val;
      end else if (idx_i > cmd_i.pos_m1) begin
        word_d = left_i;
      end
    end else if (cmd_i.del) begin
      if (idx_i >= cmd_i.pos_m1) begin
        word_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o  = word_q;
  // only slots below the count hold live entries
  assign match_o = (word_q == cmd_i.val) && (idx_i < cmd_i.count);

endmodule

// File: rtl/core/pal_chain.sv
// ----------------------------------------------------------------------------
// pal_chain: row of list cells
// Links the cells to their neighbors, gathers the match flags and selects
// the word at the read index.
// ----------------------------------------------------------------------------
module pal_chain (
  input  logic                                clk_i,
  input  pal_pkg::cmd_t                       cmd_i,
  input  logic [pal_pkg::IDX_W-1:0]           rd_idx_i,
  output logic [pal_pkg::LIST_CAPACITY-1:0]   match_o,
  output pal_pkg::word_t                      rd_word_o
);
  import pal_pkg::*;

  word_t words [LIST_CAPACITY];

  for (genvar g = 0; g < LIST_CAPACITY; g++) begin : g_cell
    word_t left_w, right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[g-1];
    end

    if (g == LIST_CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[g+1];
    end

    pal_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd_i),
      .idx_i   (CNT_W'(g)),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[g]),
      .match_o (match_o[g])
    );
  end

  assign rd_word_o = words[rd_idx_i];

endmodule

// File: rtl/core/positional_array_list_top.sv
// ----------------------------------------------------------------------------
// positional_array_list_top: bounded ordered list of 32-bit words
// Insert, delete, retrieve, locate and clear on a list of 1-based
// positions, one result word per operation word.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o) carries one operation word:
//   kind, position and value. The output channel (out_valid_o/out_ready_i)
//   returns one result word per operation: status, read value, found
//   position and the entry count after the operation.
//   An accepted word is held in an operation register and executed into
//   the result register once that register is empty or being taken.
//   Every entry sits in its own cell; shifts and compares run across all
//   cells in the execute cycle, so the block sustains one operation per
//   cycle while the receiver does not stall.
//   The receiver stalling holds the result register; the operation register
//   then fills and in_ready_o drops until the result word is taken.
//   Reset empties the list and both registers; cell contents stay unknown
//   and are never read before being written.
// ----------------------------------------------------------------------------
module positional_array_list_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        kind_i,
  input  logic [pal_pkg::POS_W-1:0]         position_i,
  input  logic signed [pal_pkg::WORD_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic signed [pal_pkg::WORD_W-1:0] read_value_o,
  output logic [pal_pkg::POS_W-1:0]         found_position_o,
  output logic [pal_pkg::POS_W-1:0]         list_count_o
);
  import pal_pkg::*;

  // operation register
  logic             op_vld_q;
  logic [2:0]       kind_q;
  logic [POS_W-1:0] pos_q;
  word_t            val_q;

  // result register
  logic             res_vld_q;
  status_e          status_q, status_d;
  word_t            rdv_q, rdv_d;
  logic [POS_W-1:0] found_q, found_d;

  cnt_t count_q, count_d;

  logic exec, in_fire;
  assign exec       = op_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !op_vld_q || exec;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_vld_q <= 1'b0;
    end else if (in_fire) begin
      op_vld_q <= 1'b1;
    end else if (exec) begin
      op_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      val_q  <= word_t'(value_i);
    end
  end

  // position checks in a common width
  logic [CMP_W-1:0] pos_x, cnt_x, cnt_p1_x;
  logic             pos_nz, full, empty, ins_pos_ok, in_range;
  logic             ins_ok, del_ok;

  assign pos_x      = CMP_W'(pos_q);
  assign cnt_x      = CMP_W'(count_q);
  assign cnt_p1_x   = cnt_x + CMP_W'(1);
  assign pos_nz     = (pos_q != '0);
  assign full       = (cnt_x >= CMP_W'(LIST_CAPACITY));
  assign empty      = (count_q == '0);
  assign ins_pos_ok = pos_nz && (pos_x <= cnt_p1_x);
  assign in_range   = pos_nz && (pos_x <= cnt_x);

  assign ins_ok = exec && (kind_q == KIND_INSERT) && !full && ins_pos_ok;
  assign del_ok = exec && (kind_q == KIND_DELETE) && !empty && in_range;

  cmd_t                     cmd;
  logic [LIST_CAPACITY-1:0] match;
  word_t                    rd_word;
  logic [POS_W-1:0]         pos_m1;

  assign pos_m1     = pos_q - POS_W'(1);
  assign cmd.ins    = ins_ok;
  assign cmd.del    = del_ok;
  assign cmd.pos_m1 = CNT_W'(pos_m1);
  assign cmd.val    = val_q;
  assign cmd.count  = count_q;

  pal_chain u_chain (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .rd_idx_i  (IDX_W'(pos_m1)),
    .match_o   (match),
    .rd_word_o (rd_word)
  );

  // first matching slot wins: scan from the top down
  logic [POS_W-1:0] locate_pos;
  always_comb begin
    locate_pos = POS_W'(cnt_p1_x);
    for (int i = LIST_CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        locate_pos = POS_W'(i + 1);
      end
    end
  end

  always_comb begin
    status_d = ST_OK;
    rdv_d    = '0;
    found_d  = '0;
    count_d  = count_q;
    case (kind_q)
      KIND_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (!ins_pos_ok) begin
          status_d = ST_BADPOS;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_DELETE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!in_range) begin
          status_d = ST_BADPOS;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      KIND_RETRIEVE: begin
        if (!in_range) begin
          status_d = ST_BADPOS;
        end else begin
          rdv_d = rd_word;
        end
      end
      KIND_LOCATE: begin
        found_d = locate_pos;
      end
      KIND_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (exec) begin
        count_q   <= count_d;
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  logic [POS_W-1:0] cnt_out_q;
  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q  <= status_d;
      rdv_q     <= rdv_d;
      found_q   <= found_d;
      cnt_out_q <= POS_W'(count_d);
    end
  end

  assign out_valid_o      = res_vld_q;
  assign status_o         = status_q;
  assign read_value_o     = $signed(rdv_q);
  assign found_position_o = found_q;
  assign list_count_o     = cnt_out_q;

endmodule

// File: tb/tb_positional_array_list_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_array_list_top: self-checking bench for the positional list
// Drives operation words through the valid/ready input channel, keeps a
// shadow copy of the list to predict every result word, and compares each
// result field by field. A short directed pass covers the empty and full
// list corners, then random traffic runs under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_positional_array_list_top;
  import pal_pkg::*;

  localparam int MAX_CYCLES    = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS   = 40;

  // Highest of the kind codes that the block treats as no operation
  localparam logic [2:0] KIND_UNUSED_LAST = 3'd7;

  typedef struct {
    status_e          status;
    word_t            read_value;
    logic [POS_W-1:0] found;
    logic [POS_W-1:0] count;
  } list_result_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [2:0]               kind_i      = '0;
  logic [POS_W-1:0]         position_i  = '0;
  logic signed [WORD_W-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [1:0]               status_o;
  logic signed [WORD_W-1:0] read_value_o;
  logic [POS_W-1:0]         found_position_o;
  logic [POS_W-1:0]         list_count_o;

  // Shadow of the list contents as the block should hold them
  word_t shadow_words [LIST_CAPACITY];
  int    shadow_len = 0;

  list_result_t pending_results [$];

  word_t corner_words [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

  int idle_pct    = 0;
  int stall_pct   = 0;
  int fill_goal   = 0;
  int errors      = 0;
  int checked     = 0;
  int sent_ops    = 0;
  int cycle_count = 0;
  int full_visits = 0;
  int kind_hits   [8];
  int status_hits [4];

  positional_array_list_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .found_position_o (found_position_o),
    .list_count_o     (list_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_REPORTS) begin
      $display("[%0t] mismatch in %s: got %h, expected %h (result %0d)", $time, field, got,
               want, checked);
    end
    errors++;
  endtask

  // Apply one operation to the shadow list and return the result word it yields
  function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input word_t val);
    list_result_t r;
    int p;
    p = int'(pos);
    r.status     = ST_OK;
    r.read_value = '0;
    r.found      = '0;
    case (op)
      KIND_INSERT: begin
        if (shadow_len >= LIST_CAPACITY) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > shadow_len + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = shadow_len; i > p - 1; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p-1] = val;
          shadow_len++;
        end
      end
      KIND_DELETE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p < 1 || p > shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = p - 1; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      KIND_RETRIEVE: begin
        if (p < 1 || p > shadow_len) r.status = ST_BADPOS;
        else r.read_value = shadow_words[p-1];
      end
      KIND_LOCATE: begin
        r.found = POS_W'(shadow_len + 1);
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] == val) begin
            r.found = POS_W'(i + 1);
            break;
          end
        end
      end
      KIND_CLEAR: shadow_len = 0;
      default: ;
    endcase
    r.count = POS_W'(shadow_len);
    return r;
  endfunction

  task automatic send_op(input logic [2:0] op, input logic [POS_W-1:0] pos, input word_t val);
    list_result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= op;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    r = apply_list_op(op, pos, val);
    pending_results.push_back(r);
    sent_ops++;
    kind_hits[op]++;
    status_hits[r.status]++;
    if (shadow_len == LIST_CAPACITY) full_visits++;
  endtask

  // Hold the input channel idle until every result word is back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", {30'b0, status_o}, '0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", {30'b0, status_o}, {30'b0, want.status});
        if (read_value_o !== want.read_value)
          report_mismatch("read_value", read_value_o, want.read_value);
        if (found_position_o !== want.found)
          report_mismatch("found_position", {27'b0, found_position_o}, {27'b0, want.found});
        if (list_count_o !== want.count)
          report_mismatch("list_count", {27'b0, list_count_o}, {27'b0, want.count});
        checked++;
      end
    end
  end

  task automatic test_empty_list();
    send_op(KIND_DELETE, POS_W'(0), 32'h0);             // empty wins over the bad position
    send_op(KIND_RETRIEVE, POS_W'(1), 32'h0);
    send_op(KIND_LOCATE, POS_W'(0), 32'hFFFF_FFFF);
    send_op(KIND_INSERT, POS_W'(2), 32'h5555_AAAA);
    send_op(KIND_UNUSED_LAST, POS_W'(31), 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_to_capacity();
    logic [POS_W-1:0] pos;
    for (int i = 0; i < LIST_CAPACITY; i++) begin
      case (i % 3)
        0:       pos = POS_W'(1);
        1:       pos = POS_W'(shadow_len + 1);
        default: pos = POS_W'(shadow_len / 2 + 1);
      endcase
      send_op(KIND_INSERT, pos, (i < 4) ? corner_words[i] : word_t'($urandom()));
    end
  endtask

  task automatic test_full_list();
    word_t absent;
    absent = 32'h1234_5678;
    for (int i = 0; i < shadow_len; i++) begin
      if (shadow_words[i] == absent) begin
        absent++;
        i = -1;  // restart the scan after a bump
      end
    end
    send_op(KIND_INSERT, POS_W'(0), 32'h0);             // full wins over the bad position
    send_op(KIND_RETRIEVE, POS_W'(16), 32'h0);
    send_op(KIND_RETRIEVE, POS_W'(31), 32'h0);
    send_op(KIND_LOCATE, POS_W'(0), 32'h7FFF_FFFF);
    send_op(KIND_LOCATE, POS_W'(0), absent);
    send_op(KIND_DELETE, POS_W'(17), 32'h0);
    send_op(KIND_DELETE, POS_W'(16), 32'h0);
    send_op(KIND_CLEAR, POS_W'(0), 32'h0);
  endtask

  task automatic send_random_op();
    int roll;
    int ins_pct;
    int del_pct;
    int span;
    logic [2:0] op;
    logic [POS_W-1:0] pos;
    word_t val;
    roll = $urandom_range(99);
    if (roll < 1) begin
      op = KIND_CLEAR;
    end else if (roll < 3) begin
      op = 3'($urandom_range(int'(KIND_UNUSED_LAST), int'(KIND_CLEAR) + 1));
    end else begin
      // Steer the fill level toward the current goal; at a full goal keep pushing
      if (shadow_len < fill_goal || fill_goal == LIST_CAPACITY) begin
        ins_pct = 55;
        del_pct = 15;
      end else begin
        ins_pct = 15;
        del_pct = 45;
      end
      roll = $urandom_range(99);
      if (roll < ins_pct) op = KIND_INSERT;
      else if (roll < ins_pct + del_pct) op = KIND_DELETE;
      else if (roll < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2) op = KIND_RETRIEVE;
      else op = KIND_LOCATE;
    end

    span = (op == KIND_INSERT) ? shadow_len + 1 : shadow_len;
    if (span == 0 || $urandom_range(99) < 15) pos = POS_W'($urandom_range(31));
    else pos = POS_W'($urandom_range(span, 1));

    roll = $urandom_range(99);
    if (shadow_len > 0 && roll < ((op == KIND_LOCATE) ? 50 : 10))
      val = shadow_words[$urandom_range(shadow_len - 1)];
    else if (roll > 89)
      val = corner_words[$urandom_range(3)];
    else
      val = $urandom();

    send_op(op, pos, val);
  endtask

  task automatic test_random_traffic(input int n_ops, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n_ops; i++) begin
      if (i % 48 == 0) begin
        case ($urandom_range(3))
          0:       fill_goal = 0;
          1:       fill_goal = LIST_CAPACITY;
          default: fill_goal = $urandom_range(LIST_CAPACITY - 1, 1);
        endcase
      end
      send_random_op();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_fill_to_capacity();
    test_full_list();
    wait_for_results();

    test_random_traffic(300, 0, 0);
    test_random_traffic(290, 69, 0);
    test_random_traffic(290, 0, 69);
    test_random_traffic(290, 24, 24);

    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d words: ins %0d, del %0d, get %0d, find %0d, clr %0d, unused %0d",
             sent_ops, kind_hits[KIND_INSERT], kind_hits[KIND_DELETE],
             kind_hits[KIND_RETRIEVE], kind_hits[KIND_LOCATE], kind_hits[KIND_CLEAR],
             kind_hits[5] + kind_hits[6] + kind_hits[7]);
    $display("Status ok %0d full %0d empty %0d badpos %0d; full %0d times; %0d checked",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_BADPOS], full_visits, checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
